// File: src/zse_pkg.sv
// zse_pkg: shared types, codes and crc/escape functions of the subpacket encoder
package zse_pkg;

  // line codes
  localparam logic [7:0] ZDLE           = 8'h18;
  localparam logic [7:0] XON            = 8'h11;
  localparam logic [7:0] FRAME_END_BASE = 8'h68;
  localparam logic [7:0] ESC_XOR        = 8'h40;
  localparam logic [7:0] PRINT_BITS     = 8'h60;
  localparam logic [6:0] AT_SIGN        = 7'h40;

  // frame end kinds
  localparam logic [1:0] END_ZCRCW = 2'd3;

  // crc constants
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC32_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ALL = 2'd1;

  // command queue depth between front and back
  localparam int unsigned CMD_DEPTH = 2;

  // back end sequencer phases
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_CODE,
    PH_CRC,
    PH_XON
  } zse_phase_e;

  // one classified command from front to back
  typedef struct packed {
    logic        is_end;
    logic        wide;
    logic        xon;
    logic [7:0]  code_byte;
    logic [31:0] trailer;
  } zse_cmd_t;

  // one msb-first crc-16 step over a byte
  function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC16_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // one reflected crc-32 step over a byte
  function automatic logic [31:0] crc32_fold(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ({1'b0, r[31:1]} ^ CRC32_POLY) : {1'b0, r[31:1]};
    end
    return r;
  endfunction

  // escape decision for a payload or crc byte
  function automatic logic needs_escape(logic [7:0] c, logic [7:0] prev, logic esc_all);
    logic r;
    if ((c & PRINT_BITS) != 8'h00) begin
      r = 1'b0;
    end else begin
      case (c) inside
        ZDLE, 8'h10, 8'h11, 8'h13, 8'h90, 8'h91, 8'h93: r = 1'b1;
        8'h0D, 8'h8D: r = esc_all || (prev[6:0] == AT_SIGN);
        default: r = esc_all;
      endcase
    end
    return r;
  endfunction

endpackage

// File: src/zse_front.sv
// zse_front: takes input items, runs the crc and builds commands for the back end
module zse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              crc32_mode_i,
  input  logic              restart_i,
  input  logic              accept_i,
  input  logic              action_i,
  input  logic [7:0]        data_byte_i,
  input  logic [1:0]        end_kind_i,
  output zse_pkg::zse_cmd_t cmd_o
);

  logic        fresh_q, fresh_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_base;
  logic [7:0]  fold_byte;
  logic [7:0]  end_code;
  logic [31:0] crc_new;

  // crc start value and the byte folded in
  assign crc_base  = fresh_q ? (crc32_mode_i ? zse_pkg::CRC32_INIT : 32'h0) : crc_q;
  assign end_code  = zse_pkg::FRAME_END_BASE + {6'b0, end_kind_i};
  assign fold_byte = action_i ? end_code : data_byte_i;

  always_comb begin
    if (crc32_mode_i) begin
      crc_new = zse_pkg::crc32_fold(crc_base, fold_byte);
    end else begin
      crc_new = {16'h0000, zse_pkg::crc16_fold(crc_base[15:0], fold_byte)};
    end
  end

  // command for the back end; trailer is laid out in send order from the low byte
  always_comb begin
    cmd_o.is_end    = action_i;
    cmd_o.wide      = crc32_mode_i;
    cmd_o.xon       = action_i && (end_kind_i == zse_pkg::END_ZCRCW);
    cmd_o.code_byte = fold_byte;
    if (crc32_mode_i) begin
      cmd_o.trailer = ~crc_new;
    end else begin
      cmd_o.trailer = {16'h0000, crc_new[7:0], crc_new[15:8]};
    end
  end

  // packet state update
  always_comb begin
    fresh_d = fresh_q;
    crc_d   = crc_q;
    if (accept_i) begin
      fresh_d = action_i;
      crc_d   = crc_new;
    end
    if (restart_i) begin
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      crc_q   <= 32'h0;
    end else begin
      fresh_q <= fresh_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// File: src/zse_queue.sv
// zse_queue: short command queue between front and back
module zse_queue #(
  parameter int unsigned Depth = zse_pkg::CMD_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  zse_pkg::zse_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output zse_pkg::zse_cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  zse_pkg::zse_cmd_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/zse_back.sv
// zse_back: expands commands into escaped line bytes with an output register
module zse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              esc_all_i,
  input  logic              cmd_valid_i,
  input  zse_pkg::zse_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        line_byte_o,
  output logic              last_of_run_o
);

  zse_pkg::zse_phase_e phase_q, phase_d;
  logic [1:0] idx_q, idx_d;
  logic       esc_q;
  logic [7:0] prev_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       load, step;
  logic [7:0] cur, escd;
  logic [1:0] last_idx;
  logic       esc_need;
  logic [7:0] emit_byte;
  logic       emit_last, done, set_esc, upd_prev;

  assign load     = !out_valid_q || pop_i;
  assign step     = cmd_valid_i && load;
  assign last_idx = cmd_i.wide ? 2'd3 : 2'd1;
  assign cur      = (phase_q == zse_pkg::PH_CRC) ? cmd_i.trailer[{idx_q, 3'b000} +: 8]
                                                 : cmd_i.code_byte;
  assign esc_need = zse_pkg::needs_escape(cur, prev_q, esc_all_i);
  assign escd     = esc_q ? (cur ^ zse_pkg::ESC_XOR) : cur;

  // byte emitted by the current phase
  always_comb begin
    emit_byte = zse_pkg::ZDLE;
    emit_last = 1'b0;
    done      = 1'b0;
    set_esc   = 1'b0;
    upd_prev  = 1'b0;
    unique case (phase_q)
      zse_pkg::PH_FIRST: begin
        if (cmd_i.is_end) begin
          emit_byte = zse_pkg::ZDLE;
        end else if (esc_need && !esc_q) begin
          set_esc = 1'b1;
        end else begin
          emit_byte = escd;
          emit_last = 1'b1;
          done      = 1'b1;
          upd_prev  = 1'b1;
        end
      end
      zse_pkg::PH_CODE: begin
        emit_byte = cmd_i.code_byte;
      end
      zse_pkg::PH_CRC: begin
        if (esc_need && !esc_q) begin
          set_esc = 1'b1;
        end else begin
          emit_byte = escd;
          upd_prev  = 1'b1;
          if (idx_q == last_idx) begin
            emit_last = !cmd_i.xon;
            done      = !cmd_i.xon;
          end
        end
      end
      zse_pkg::PH_XON: begin
        emit_byte = zse_pkg::XON;
        emit_last = 1'b1;
        done      = 1'b1;
      end
      default: begin
        emit_byte = zse_pkg::ZDLE;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (step) begin
      unique case (phase_q)
        zse_pkg::PH_FIRST: begin
          if (cmd_i.is_end) begin
            phase_d = zse_pkg::PH_CODE;
          end
        end
        zse_pkg::PH_CODE: begin
          phase_d = zse_pkg::PH_CRC;
          idx_d   = 2'd0;
        end
        zse_pkg::PH_CRC: begin
          if (!set_esc) begin
            if (idx_q == last_idx) begin
              phase_d = cmd_i.xon ? zse_pkg::PH_XON : zse_pkg::PH_FIRST;
              idx_d   = 2'd0;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
        zse_pkg::PH_XON: begin
          phase_d = zse_pkg::PH_FIRST;
        end
        default: begin
          phase_d = zse_pkg::PH_FIRST;
        end
      endcase
    end
  end

  assign cmd_pop_o = step && done;

  // sequencer and escape history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= zse_pkg::PH_FIRST;
      idx_q   <= 2'd0;
      esc_q   <= 1'b0;
      prev_q  <= 8'h00;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (step) begin
        esc_q <= set_esc;
        if (upd_prev) begin
          prev_q <= escd;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign line_byte_o   = out_byte_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  // a pending escape prefix only exists while a payload or crc byte is due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == zse_pkg::PH_FIRST || phase_q == zse_pkg::PH_CRC))
    else $error("escape prefix pending in wrong phase");

  // a command in progress stays at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != zse_pkg::PH_FIRST || esc_q) |-> cmd_valid_i)
    else $error("command left queue mid-sequence");

  // a 16-bit trailer never walks past its second byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == zse_pkg::PH_CRC && !cmd_i.wide) |-> !idx_q[1])
    else $error("crc byte index out of range");

  // a stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_byte_q)))
    else $error("output register overwritten while stalled");
`endif

endmodule

// File: src/zmodem_subpacket_encoder.sv
// zmodem_subpacket_encoder: top level of the data subpacket framer
//
// Input channel: push/full. Each transaction carries one item: a data byte
// (action_i = 0) or an end of subpacket (action_i = 1, end_kind_i picks
// ZCRCE/ZCRCG/ZCRCQ/ZCRCW). Result channel: empty/pop. Each transaction is
// one line byte; last_of_run_o marks the final byte caused by an item.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; index 0 selects the 32-bit crc (and restarts the packet crc),
// index 1 turns on escaping of all control bytes. Write config only when idle.
// An item is registered in the command queue and its line bytes in the output
// register. The back end sends one line byte per cycle while pop is not
// stalled, so a data byte gives 1 or 2 line bytes and an end item 4 to 11;
// the front end folds one byte into the crc per cycle while full is low, and a
// two-entry command queue lets it run ahead.
// A stalled pop holds the output register; the queue then fills and full
// rises. Reset clears config, crc state and queues; the first item starts
// a fresh packet.
module zmodem_subpacket_encoder #(
  parameter int unsigned CmdDepth = zse_pkg::CMD_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         push,
  output logic                         full,
  input  logic                         action_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [1:0]                   end_kind_i,
  // result bytes
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   line_byte_o,
  output logic                         last_of_run_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [zse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                         cfg_data_i
);

  logic              crc32_mode_q, esc_all_q;
  logic              restart;
  logic              accept;
  zse_pkg::zse_cmd_t front_cmd, head_cmd;
  logic              head_valid, head_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i && (cfg_index_i == zse_pkg::CFG_CRC32_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc32_mode_q <= 1'b0;
      esc_all_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        zse_pkg::CFG_CRC32_MODE: crc32_mode_q <= cfg_data_i;
        zse_pkg::CFG_ESCAPE_ALL: esc_all_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // front: crc and classification
  zse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .crc32_mode_i (crc32_mode_q),
    .restart_i    (restart),
    .accept_i     (accept),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .end_kind_i   (end_kind_i),
    .cmd_o        (front_cmd)
  );

  // command queue
  zse_queue #(
    .Depth (CmdDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  // back: escaping and line byte sequencing
  zse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .esc_all_i     (esc_all_q),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (head_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .line_byte_o   (line_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: verif/zmodem_subpacket_encoder_checker.sv
`timescale 1ns / 100ps
// zmodem_subpacket_encoder_checker: line byte predictor and scoreboard for the subpacket encoder
module zmodem_subpacket_encoder_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  logic                          action_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [1:0]                    end_kind_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [7:0]                    line_byte_o,
  input  logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [zse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  output int unsigned                   err_count_o,
  output int unsigned                   pending_o
);

  // line codes and crc parameters
  localparam logic [7:0]  ZDLE_BYTE     = 8'h18;
  localparam logic [7:0]  XON_BYTE      = 8'h11;
  localparam logic [7:0]  END_CODE_BASE = 8'h68;
  localparam logic [7:0]  ESC_FLIP      = 8'h40;
  localparam logic [7:0]  PRINTABLE     = 8'h60;
  localparam logic [6:0]  AT_CHAR       = 7'h40;
  localparam logic [6:0]  CR_CHAR       = 7'h0d;
  localparam logic [1:0]  KIND_ZCRCW    = 2'd3;
  localparam logic [15:0] CRC16_GEN     = 16'h1021;
  localparam logic [31:0] CRC32_GEN     = 32'hEDB88320;
  localparam logic [31:0] CRC32_SEED    = 32'hFFFFFFFF;
  localparam logic        ACT_END       = 1'b1;
  localparam int          MAX_RUN       = 11;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last;
  } line_beat_t;

  line_beat_t  expected_line_q[$];

  // mirrored encoder state
  logic        crc32_sel;
  logic        escape_all;
  logic [31:0] crc_run;
  logic        new_packet;
  logic [7:0]  last_escapable;

  // line bytes of the item being framed
  logic [7:0]  run_bytes[MAX_RUN];
  int          run_len;
  int unsigned mismatches;

  // bit-serial crc-16/xmodem, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC16_GEN;
    end
    return r;
  endfunction

  // bit-serial reflected crc-32, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = {1'b0, r[31:1]};
      if (fb) r = r ^ CRC32_GEN;
    end
    return r;
  endfunction

  task automatic crc_absorb(input logic [7:0] b);
    if (crc32_sel) begin
      crc_run = crc32_byte(crc_run, b);
    end else begin
      crc_run = {16'h0000, crc16_byte(crc_run[15:0], b)};
    end
  endtask

  task automatic put_raw(input logic [7:0] b);
    run_bytes[run_len] = b;
    run_len++;
  endtask

  // zdle escaping of a payload or crc byte
  task automatic put_escaped(input logic [7:0] b);
    logic       esc;
    logic [7:0] c;
    c = b;
    if ((c & PRINTABLE) != 8'h00) begin
      esc = 1'b0;
    end else begin
      case (c)
        ZDLE_BYTE, 8'h10, 8'h11, 8'h13, 8'h90, 8'h91, 8'h93: esc = 1'b1;
        default: begin
          if (c[6:0] == CR_CHAR) begin
            esc = escape_all || (last_escapable[6:0] == AT_CHAR);
          end else begin
            esc = escape_all;
          end
        end
      endcase
    end
    if (esc) begin
      put_raw(ZDLE_BYTE);
      c = c ^ ESC_FLIP;
    end
    last_escapable = c;
    put_raw(c);
  endtask

  // frame one input item into its expected line bytes
  task automatic frame_item(input logic act, input logic [7:0] data, input logic [1:0] kind);
    logic [7:0]  code;
    logic [31:0] v;
    line_beat_t  beat;
    if (new_packet) begin
      crc_run    = crc32_sel ? CRC32_SEED : 32'h0;
      new_packet = 1'b0;
    end
    run_len = 0;
    if (act != ACT_END) begin
      put_escaped(data);
      crc_absorb(data);
    end else begin
      code = END_CODE_BASE + {6'd0, kind};
      put_raw(ZDLE_BYTE);
      put_raw(code);
      crc_absorb(code);
      if (crc32_sel) begin
        v = ~crc_run;
        for (int k = 0; k < 4; k++) begin
          put_escaped(v[7:0]);
          v = v >> 8;
        end
      end else begin
        put_escaped(crc_run[15:8]);
        put_escaped(crc_run[7:0]);
      end
      if (kind == KIND_ZCRCW) put_raw(XON_BYTE);
      new_packet = 1'b1;
    end
    for (int k = 0; k < run_len; k++) begin
      beat.line_byte = run_bytes[k];
      beat.last      = (k == run_len - 1);
      expected_line_q.push_back(beat);
    end
  endtask

  // watch config, input and result channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_beat_t want;
    if (!rst_ni) begin
      crc32_sel      = 1'b0;
      escape_all     = 1'b0;
      crc_run        = 32'h0;
      new_packet     = 1'b1;
      last_escapable = 8'h00;
      mismatches     = 0;
      expected_line_q.delete();
      err_count_o   <= 0;
      pending_o     <= 0;
    end else begin
      // config transaction
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          zse_pkg::CFG_CRC32_MODE: begin
            crc32_sel  = cfg_data_i;
            new_packet = 1'b1;
          end
          zse_pkg::CFG_ESCAPE_ALL: escape_all = cfg_data_i;
          default: ;
        endcase
      end
      // input transaction
      if (push && !full) frame_item(action_i, data_byte_i, end_kind_i);
      // result transaction
      if (pop && !empty) begin
        if (expected_line_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected line byte %02h last %0b", $time, line_byte_o,
                     last_of_run_o);
          end
        end else begin
          want = expected_line_q.pop_front();
          if (want.line_byte !== line_byte_o || want.last !== last_of_run_o) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: line byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $time, want.line_byte, want.last, line_byte_o, last_of_run_o);
            end
          end
        end
      end
      pending_o   <= expected_line_q.size();
      err_count_o <= mismatches;
    end
  end

endmodule

// File: verif/zmodem_subpacket_encoder_tb.sv
`timescale 1ns / 100ps
// zmodem_subpacket_encoder_tb: stimulus, flow control and verdict for the subpacket encoder
module zmodem_subpacket_encoder_tb;

  localparam logic       ACT_DATA        = 1'b0;
  localparam logic       ACT_END         = 1'b1;
  localparam logic [1:0] KIND_ZCRCE      = 2'd0;
  localparam logic [1:0] KIND_ZCRCG      = 2'd1;
  localparam logic [1:0] KIND_ZCRCQ      = 2'd2;
  localparam logic [1:0] KIND_ZCRCW      = 2'd3;
  localparam logic [zse_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [zse_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         PHASE_ITEMS     = 40;
  localparam int         DRAIN_CYCLES    = 20;
  localparam time        RUN_LIMIT       = 5ms;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic [1:0]  end_kind_i = 2'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  line_byte_o;
  logic        last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [zse_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic        cfg_data_i = 1'b0;

  int unsigned err_count;
  int unsigned pending_results;
  int          burst_left = 0;
  logic        hold_off_req = 1'b0;

  // bytes that exercise the escape rules
  logic [7:0]  touchy_bytes[13] = '{8'h18, 8'h10, 8'h11, 8'h13, 8'h90, 8'h91, 8'h93,
                                    8'h0d, 8'h8d, 8'h40, 8'hc0, 8'h00, 8'h1f};

  zmodem_subpacket_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .end_kind_i    (end_kind_i),
    .empty         (empty),
    .pop           (pop),
    .line_byte_o   (line_byte_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  zmodem_subpacket_encoder_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .end_kind_i    (end_kind_i),
    .empty         (empty),
    .pop           (pop),
    .line_byte_o   (line_byte_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (err_count),
    .pending_o     (pending_results)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("zmodem_subpacket_encoder_tb: done, errors");
    $finish;
  end

  // one in three payload bytes from the escape set, the rest fully random
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) begin
      b = touchy_bytes[$urandom_range(0, 12)];
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // one input transaction, with bursts and gaps
  task automatic offer_item(input logic act, input logic [7:0] data, input logic [1:0] kind);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = hold_off_req ? 0 : $urandom_range(0, 6);
      if (gap_len > 0) begin
        push <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    push        <= 1'b1;
    action_i    <= act;
    data_byte_i <= data;
    end_kind_i  <= kind;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
  endtask

  // stop sending and wait for every expected line byte
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [zse_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // write both registers plus one unused index, valid held across the beats
  task automatic apply_settings(input logic crc32, input logic esc_all);
    drain_results();
    cfg_beat($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, 1'($urandom_range(0, 1)));
    cfg_beat(zse_pkg::CFG_CRC32_MODE, crc32);
    cfg_beat(zse_pkg::CFG_ESCAPE_ALL, esc_all);
    cfg_valid_i <= 1'b0;
  endtask

  // packets of random length, some empty; a phase may stop mid-packet
  task automatic run_phase(input int n_items);
    int sent;
    int pkt_len;
    sent = 0;
    while (sent < n_items) begin
      pkt_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
      for (int k = 0; k < pkt_len && sent < n_items; k++) begin
        offer_item(ACT_DATA, pick_payload(), 2'($urandom_range(0, 3)));
        sent++;
      end
      if (sent < n_items) begin
        offer_item(ACT_END, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        sent++;
      end
    end
  endtask

  // receiver: random stall shapes, plus one long hold-off
  initial begin : receiver
    int pop_pct;
    int shape_left;
    pop_pct    = 100;
    shape_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (shape_left == 0) begin
          shape_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: pop_pct = 100;
            1: pop_pct = 60;
            2: pop_pct = 25;
            default: pop_pct = 10;
          endcase
        end
        shape_left--;
        pop <= ($urandom_range(1, 100) <= pop_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: escape cases at reset settings, crc-16
    offer_item(ACT_DATA, 8'h00, KIND_ZCRCW);
    offer_item(ACT_DATA, 8'hff, KIND_ZCRCQ);
    for (int k = 0; k < 7; k++) begin
      offer_item(ACT_DATA, touchy_bytes[k], 2'($urandom_range(0, 3)));
    end
    // cr after '@', after a high-bit '@', then a plain cr
    offer_item(ACT_DATA, 8'h40, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'h0d, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'hc0, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'h8d, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'h0d, KIND_ZCRCE);
    offer_item(ACT_END, 8'h5a, KIND_ZCRCE);
    // empty packet, then the remaining end kinds
    offer_item(ACT_END, 8'ha5, KIND_ZCRCG);
    offer_item(ACT_DATA, 8'h7f, KIND_ZCRCG);
    offer_item(ACT_END, 8'hff, KIND_ZCRCQ);
    offer_item(ACT_END, 8'h00, KIND_ZCRCW);
    // crc-32 with every control byte escaped, mode change mid-packet after
    apply_settings(1'b1, 1'b1);
    offer_item(ACT_DATA, 8'h01, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'h1f, KIND_ZCRCE);
    offer_item(ACT_DATA, 8'h80, KIND_ZCRCE);
    offer_item(ACT_END, 8'h18, KIND_ZCRCW);
    offer_item(ACT_DATA, 8'h55, KIND_ZCRCE);

    // random phases over the register settings
    apply_settings(1'b0, 1'b1);
    hold_off_req = 1'b1;
    run_phase(PHASE_ITEMS);
    apply_settings(1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    apply_settings(1'b1, 1'b1);
    run_phase(PHASE_ITEMS);
    apply_settings(1'b0, 1'b0);
    run_phase(PHASE_ITEMS);
    apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_phase(PHASE_ITEMS);
    apply_settings(1'b1, 1'b0);
    run_phase(PHASE_ITEMS);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("zmodem_subpacket_encoder_tb: done, clean");
    end else begin
      $display("zmodem_subpacket_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule
